@@ rtl/pvb_pkg.sv @@
// Package for the point voxel binner: shared types, operation codes,
// register indexes and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvb_pkg;

  localparam int MAX_CELLS_PER_AXIS = 64;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int SIZE_W  = 24;
  localparam int COUNT_W = 7;
  localparam int INT_W   = 16;
  localparam int CELL_W  = 6;
  localparam int FLAT_W  = 18;
  localparam int OFF_W   = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 192;

  localparam int DIV_W    = 32;
  localparam int DIV_STEP = 4;
  localparam int DIV_ITER = DIV_W / DIV_STEP;
  localparam int DIV_CW   = $clog2(DIV_ITER + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_BIN   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_NORM  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [SIZE_W-1:0]         cell_size_x;
    logic [SIZE_W-1:0]         cell_size_y;
    logic [SIZE_W-1:0]         cell_size_z;
    logic [COUNT_W-1:0]        cells_x;
    logic [COUNT_W-1:0]        cells_y;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] diff_z;
    logic [SIZE_W-1:0]        sz_x;
    logic [SIZE_W-1:0]        sz_y;
    logic [SIZE_W-1:0]        sz_z;
    logic [INT_W-1:0]         intensity;
    logic [CELL_W-1:0]        qx;
    logic [CELL_W-1:0]        qy;
    logic [CELL_W-1:0]        qz;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [FLAT_W-1:0] flat_index;
    logic [OFF_W-1:0]  offset_x;
    logic [OFF_W-1:0]  offset_y;
    logic [OFF_W-1:0]  offset_z;
    logic              out_of_grid;
    logic              is_floor;
    logic [INT_W-1:0]  normalized_intensity;
    logic [INT_W-1:0]  min_seen_intensity;
    logic [INT_W-1:0]  max_seen_intensity;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/pvb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/pvb_div.sv @@
// Iterative restoring divider, DIV_STEP quotient bits per cycle while busy.
// Depends on pvb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvb_div import pvb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output logic                   busy,
  output logic      [DIV_W-1:0]  quotient
);

  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W-1:0] rem, rem_next;
  logic [DIV_W-1:0]  quo_next;
  logic [DIV_CW-1:0] cnt;

  always_comb begin
    logic [SIZE_W:0] t;
    rem_next = rem;
    quo_next = quotient;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = t[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CW'(DIV_ITER);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pvb_front.sv @@
// Front end: accepts input transactions, unpacks them, forms the offsets
// from the grid origin and the effective cell sizes. Depends on pvb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvb_front import pvb_pkg::*; (
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]           s_tuser,
  input  wire cfg_t                 cfg,
  input  wire logic                 clearing,
  input  wire logic                 q_full,
  output logic                      q_push,
  output item_t                     q_item
);

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s == '0) ? SIZE_W'(1) : s;
  endfunction

  logic signed [COORD_W-1:0] px, py, pz;

  assign px = s_tdata[31:0];
  assign py = s_tdata[63:32];
  assign pz = s_tdata[95:64];

  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_item.op        = s_tuser;
    q_item.diff_x    = DIFF_W'(px) - DIFF_W'(cfg.origin_x);
    q_item.diff_y    = DIFF_W'(py) - DIFF_W'(cfg.origin_y);
    q_item.diff_z    = DIFF_W'(pz) - DIFF_W'(cfg.origin_z);
    q_item.sz_x      = eff_size(cfg.cell_size_x);
    q_item.sz_y      = eff_size(cfg.cell_size_y);
    q_item.sz_z      = eff_size(cfg.cell_size_z);
    q_item.intensity = s_tdata[111:96];
    q_item.qx        = s_tdata[117:112];
    q_item.qy        = s_tdata[123:118];
    q_item.qz        = s_tdata[129:124];
  end

endmodule
`default_nettype wire

@@ rtl/pvb_queue.sv @@
// Short FIFO of classified items between front and back end.
// Depends on pvb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvb_queue import pvb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t        entries [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pvb_back.sv @@
// Back end: divides, saturates, multiplies out indices and offsets, keeps
// the column floor table and intensity extremes, holds the result register.
// Depends on pvb_pkg, pvb_div, pvb_ram.
`timescale 1ns / 1ps
`default_nettype none
module pvb_back import pvb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire item_t q_head,
  output logic       q_pop,
  output logic       clearing,
  output logic       res_valid,
  output result_t    res,
  input  wire logic  res_ready
);

  localparam int MAX_CELLS = MAX_CELLS_PER_AXIS;
  localparam int CW    = $clog2(MAX_CELLS);
  localparam int NW    = $clog2(MAX_CELLS + 1);
  localparam int DEPTH = MAX_CELLS * MAX_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = CW + 1;
  localparam int PW    = CW + 1 + SIZE_W;
  localparam int OW    = ((PW > OFF_W) ? PW : OFF_W) + 2;
  localparam int FLW   = (CW + 2 * NW + 1 > FLAT_W) ? CW + 2 * NW + 1 : FLAT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  function automatic logic [NW-1:0] eff_cnt(input logic [COUNT_W-1:0] c);
    if (c == '0) begin
      return NW'(1);
    end else if (int'(c) > MAX_CELLS) begin
      return NW'(MAX_CELLS);
    end
    return NW'(c);
  endfunction

  // {flag, cell}
  function automatic logic [CW:0] bin_cell(input logic signed [DIFF_W-1:0] d,
                                           input logic [DIV_W-1:0] q,
                                           input logic [NW-1:0] n);
    logic [NW-1:0] nm1;
    nm1 = n - NW'(1);
    if (d < 0) begin
      return {1'b1, {CW{1'b0}}};
    end else if (q > DIV_W'(nm1)) begin
      return {1'b1, CW'(nm1)};
    end
    return {1'b0, q[CW-1:0]};
  endfunction

  function automatic logic [OFF_W-1:0] sat_off(input logic signed [DIFF_W-1:0] d,
                                               input logic [PW-1:0] p);
    logic signed [OW-1:0] w;
    w = (OW'(d) <<< 1) - $signed({{(OW-PW){1'b0}}, p});
    if (w[OW-1:OFF_W-1] == '0 || w[OW-1:OFF_W-1] == '1) begin
      return w[OFF_W-1:0];
    end else if (w[OW-1]) begin
      return {1'b1, {(OFF_W-1){1'b0}}};
    end
    return {1'b0, {(OFF_W-1){1'b1}}};
  endfunction

  logic [2:0]      state;
  item_t           it;
  logic [NW-1:0]   nx, ny;
  logic [2*NW-1:0] nxy;
  logic [INT_W-1:0] low, high;

  logic              div_start, div_busy;
  logic [DIV_W-1:0]  dvd_x, qt_x, qt_y, qt_z;
  logic [SIZE_W-1:0] dvs_x;
  logic              norm_ok;
  logic [INT_W-1:0]  norm_q;

  logic [CW-1:0]      cx, cy, cz;
  logic               flag, qok;
  logic [CW:0]        bx, by, bz;
  logic [PW-1:0]      prod_x, prod_y, prod_z;
  logic [CW+NW-1:0]   cy_nx;
  logic [CW+2*NW-1:0] cz_nxy;
  logic [AW-1:0]      col;
  logic [OFF_W-1:0]   off_x, off_y, off_z;
  logic [FLW-1:0]     flat;

  logic           ram_we, ram_re, wb_fire, floor_upd;
  logic [AW-1:0]  ram_waddr, clr_cnt;
  logic [FW-1:0]  ram_wdata, ram_rdata;
  logic [INT_W-1:0] low_next, high_next;
  result_t        res_next;

  assign nx = eff_cnt(cfg.cells_x);
  assign ny = eff_cnt(cfg.cells_y);

  always_ff @(posedge clk) begin
    nxy <= nx * ny;
  end

  assign q_pop     = (state == ST_IDLE) && !q_empty && !clearing;
  assign div_start = q_pop;
  assign dvd_x = (q_head.op == OP_NORM) ? {q_head.intensity - low, {INT_W{1'b0}}}
               : (q_head.diff_x[DIFF_W-1] ? '0 : q_head.diff_x[DIV_W-1:0]);
  assign dvs_x = (q_head.op == OP_NORM) ? SIZE_W'(high - low) : q_head.sz_x;

  pvb_div u_div_x (
    .clk, .rst, .start(div_start), .dividend(dvd_x), .divisor(dvs_x),
    .busy(div_busy), .quotient(qt_x)
  );
  pvb_div u_div_y (
    .clk, .rst, .start(div_start),
    .dividend(q_head.diff_y[DIFF_W-1] ? '0 : q_head.diff_y[DIV_W-1:0]),
    .divisor(q_head.sz_y), .busy(), .quotient(qt_y)
  );
  pvb_div u_div_z (
    .clk, .rst, .start(div_start),
    .dividend(q_head.diff_z[DIFF_W-1] ? '0 : q_head.diff_z[DIV_W-1:0]),
    .divisor(q_head.sz_z), .busy(), .quotient(qt_z)
  );

  assign bx = bin_cell(it.diff_x, qt_x, nx);
  assign by = bin_cell(it.diff_y, qt_y, ny);
  assign bz = bin_cell(it.diff_z, qt_z, NW'(MAX_CELLS));

  assign wb_fire   = (state == ST_WB) && (!res_valid || res_ready);
  assign floor_upd = wb_fire && (it.op == OP_BIN) && (FW'(cy) < ram_rdata);
  assign low_next  = (it.op == OP_BIN && it.intensity < low) ? it.intensity : low;
  assign high_next = (it.op == OP_BIN && it.intensity > high) ? it.intensity : high;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      clearing <= 1'b1;
      clr_cnt  <= '0;
      low      <= '1;
      high     <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_RD;
        ST_RD:  state <= ST_WB;
        ST_WB: begin
          if (wb_fire) begin
            state <= ST_IDLE;
            low   <= low_next;
            high  <= high_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it      <= q_head;
      norm_ok <= (high > low) && (q_head.intensity > low);
    end
    if (state == ST_DIV && !div_busy) begin
      cx     <= bx[CW-1:0];
      cy     <= by[CW-1:0];
      cz     <= bz[CW-1:0];
      flag   <= bx[CW] | by[CW] | bz[CW];
      norm_q <= (qt_x[DIV_W-1:INT_W] != '0) ? '1 : qt_x[INT_W-1:0];
      qok    <= (int'(it.qx) < int'(nx)) && (int'(it.qy) < int'(ny))
                && (int'(it.qz) < MAX_CELLS);
    end
    if (state == ST_MUL) begin
      prod_x <= PW'({cx, 1'b1}) * PW'(it.sz_x);
      prod_y <= PW'({cy, 1'b1}) * PW'(it.sz_y);
      prod_z <= PW'({cz, 1'b1}) * PW'(it.sz_z);
      cy_nx  <= (CW+NW)'(cy) * (CW+NW)'(nx);
      cz_nxy <= (CW+2*NW)'(cz) * (CW+2*NW)'(nxy);
      if (it.op == OP_QUERY) begin
        col <= AW'(it.qx) + AW'(it.qz) * AW'(nx);
      end else begin
        col <= AW'(cx) + AW'(cz) * AW'(nx);
      end
    end
    if (state == ST_RD) begin
      off_x <= sat_off(it.diff_x, prod_x);
      off_y <= sat_off(it.diff_y, prod_y);
      off_z <= sat_off(it.diff_z, prod_z);
      flat  <= FLW'(cx) + FLW'(cy_nx) + FLW'(cz_nxy);
    end
  end

  assign ram_re    = (state == ST_RD);
  assign ram_we    = clearing || floor_upd;
  assign ram_waddr = clearing ? clr_cnt : col;
  assign ram_wdata = clearing ? '1 : FW'(cy);

  pvb_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_floor_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(col), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (wb_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    res_next = '0;
    if (it.op == OP_BIN) begin
      res_next.cell_x      = CELL_W'(cx);
      res_next.cell_y      = CELL_W'(cy);
      res_next.cell_z      = CELL_W'(cz);
      res_next.flat_index  = flat[FLAT_W-1:0];
      res_next.offset_x    = off_x;
      res_next.offset_y    = off_y;
      res_next.offset_z    = off_z;
      res_next.out_of_grid = flag;
    end
    if (it.op == OP_QUERY) begin
      res_next.is_floor = qok && (ram_rdata == FW'(it.qy));
    end
    if (it.op == OP_NORM && norm_ok) begin
      res_next.normalized_intensity = norm_q;
    end
    res_next.min_seen_intensity = low_next;
    res_next.max_seen_intensity = high_next;
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      res <= res_next;
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop) else $error("item taken during table clear");

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD && it.op == OP_BIN) |-> (int'(cx) < int'(nx)))
    else $error("x cell beyond count");

  a_write_only_wb: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clearing) |-> (state == ST_WB))
    else $error("floor table written outside write-back");

  a_mul_to_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_RD && ram_re))
    else $error("table read not issued after multiply");

endmodule
`default_nettype wire

@@ rtl/point_voxel_binner.sv @@
// Point voxel binner top level: configuration registers, front end, queue,
// back end. Depends on pvb_pkg, pvb_front, pvb_queue, pvb_back.
//
// Input stream s_*: one transaction per item, operation in s_tuser
// (bin point, floor query, normalize intensity). Output stream m_*: exactly
// one result transaction per input transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while the block is idle.
// The back end handles one item at a time and takes no new item until the
// last one is written back; its steps are queue pop, divide (8 iterations
// of 4 quotient bits, then the cell capture), multiply, table read and
// write-back.
// A two-entry queue lets the front accept items while the back is busy.
// Reset: registers return to defaults, extremes reset, then the column floor
// table is swept to "no cell", one entry per cycle, over all
// MAX_CELLS_PER_AXIS^2 entries (4096); s_tready stays low during the sweep.
// When m_tready is low the result is held and the back end stalls at
// write-back; the queue then fills and s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module point_voxel_binner import pvb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // point_x, point_y, point_z, intensity, query_cell_x, query_cell_y,
  // query_cell_z, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // cell_x, cell_y, cell_z, flat_index, offset_x, offset_y, offset_z,
  // out_of_grid, is_floor, normalized_intensity, min_seen_intensity,
  // max_seen_intensity, zero pad
  output logic      [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   push_item, head;
  logic    q_push, q_pop, q_full, q_empty, clearing;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.origin_z    <= '0;
      cfg.cell_size_x <= SIZE_W'(256);
      cfg.cell_size_y <= SIZE_W'(256);
      cfg.cell_size_z <= SIZE_W'(256);
      cfg.cells_x     <= COUNT_W'(10);
      cfg.cells_y     <= COUNT_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: cfg.origin_x    <= cfg_data;
        REG_ORIGIN_Y: cfg.origin_y    <= cfg_data;
        REG_ORIGIN_Z: cfg.origin_z    <= cfg_data;
        REG_SIZE_X:   cfg.cell_size_x <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:   cfg.cell_size_y <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:   cfg.cell_size_z <= cfg_data[SIZE_W-1:0];
        REG_CELLS_X:  cfg.cells_x     <= cfg_data[COUNT_W-1:0];
        REG_CELLS_Y:  cfg.cells_y     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pvb_front u_front (
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .cfg, .clearing,
    .q_full, .q_push, .q_item(push_item)
  );

  pvb_queue u_queue (
    .clk, .rst, .push(q_push), .push_item, .pop(q_pop), .head,
    .full(q_full), .empty(q_empty)
  );

  pvb_back u_back (
    .clk, .rst, .cfg, .q_empty, .q_head(head), .q_pop, .clearing,
    .res_valid(m_tvalid), .res, .res_ready(m_tready)
  );

  assign m_tdata = {4'b0, res.max_seen_intensity, res.min_seen_intensity,
                    res.normalized_intensity, res.is_floor, res.out_of_grid,
                    res.offset_z, res.offset_y, res.offset_x, res.flat_index,
                    res.cell_z, res.cell_y, res.cell_x};

endmodule
`default_nettype wire

@@ verif/pvb_checker.sv @@
// Checker for the point voxel binner: watches the input, output and register
// write channels, predicts every result and compares it field by field.
// Depends on pvb_pkg.
`timescale 1ns / 1ps
module pvb_checker import pvb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  localparam int NMAX = 64;
  localparam longint OFF_HI = 64'sd8589934591;
  localparam longint OFF_LO = -64'sd8589934592;

  cfg_t           shadow;
  logic [6:0]     floor_tbl [NMAX*NMAX];
  logic [INT_W-1:0] low_seen, high_seen;
  result_t        expected_results [$];

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int eff_count(input logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > NMAX) return NMAX;
    return c;
  endfunction

  function automatic void bin_axis(input logic signed [COORD_W-1:0] p,
                                   input logic signed [COORD_W-1:0] org,
                                   input logic [SIZE_W-1:0] size, input int n,
                                   inout logic flag, output int cell_idx,
                                   output logic [OFF_W-1:0] off);
    longint diff, sz, q, o;
    diff = longint'(p) - longint'(org);
    sz = (size == 0) ? 1 : longint'(size);
    if (diff < 0) begin
      cell_idx = 0;
      flag = 1'b1;
    end else begin
      q = diff / sz;
      if (q > n - 1) begin
        q = n - 1;
        flag = 1'b1;
      end
      cell_idx = int'(q);
    end
    o = 2 * diff - (2 * longint'(cell_idx) + 1) * sz;
    if (o > OFF_HI) o = OFF_HI;
    if (o < OFF_LO) o = OFF_LO;
    off = o[OFF_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    result_t r, got;
    int nx, ny, cx, cy, cz, col;
    logic flag;
    logic [INT_W-1:0] v;
    logic [5:0] qx, qy, qz;
    longint num;
    if (rst) begin
      shadow.origin_x = '0;
      shadow.origin_y = '0;
      shadow.origin_z = '0;
      shadow.cell_size_x = 24'd256;
      shadow.cell_size_y = 24'd256;
      shadow.cell_size_z = 24'd256;
      shadow.cells_x = 7'd10;
      shadow.cells_y = 7'd10;
      foreach (floor_tbl[i]) floor_tbl[i] = 7'h7f;
      low_seen = 16'hffff;
      high_seen = 16'h0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: shadow.origin_x = cfg_data;
          REG_ORIGIN_Y: shadow.origin_y = cfg_data;
          REG_ORIGIN_Z: shadow.origin_z = cfg_data;
          REG_SIZE_X:   shadow.cell_size_x = cfg_data[SIZE_W-1:0];
          REG_SIZE_Y:   shadow.cell_size_y = cfg_data[SIZE_W-1:0];
          REG_SIZE_Z:   shadow.cell_size_z = cfg_data[SIZE_W-1:0];
          REG_CELLS_X:  shadow.cells_x = cfg_data[COUNT_W-1:0];
          REG_CELLS_Y:  shadow.cells_y = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        r = '0;
        nx = eff_count(shadow.cells_x);
        ny = eff_count(shadow.cells_y);
        v = s_tdata[111:96];
        qx = s_tdata[117:112];
        qy = s_tdata[123:118];
        qz = s_tdata[129:124];
        case (s_tuser)
          OP_BIN: begin
            flag = 1'b0;
            bin_axis(s_tdata[31:0], shadow.origin_x, shadow.cell_size_x, nx,
                     flag, cx, r.offset_x);
            bin_axis(s_tdata[63:32], shadow.origin_y, shadow.cell_size_y, ny,
                     flag, cy, r.offset_y);
            bin_axis(s_tdata[95:64], shadow.origin_z, shadow.cell_size_z, NMAX,
                     flag, cz, r.offset_z);
            col = (cx + cz * nx) % (NMAX * NMAX);
            if (cy < floor_tbl[col]) floor_tbl[col] = cy[6:0];
            if (v < low_seen) low_seen = v;
            if (v > high_seen) high_seen = v;
            r.cell_x = cx[5:0];
            r.cell_y = cy[5:0];
            r.cell_z = cz[5:0];
            r.flat_index = 18'(cx + cy * nx + cz * nx * ny);
            r.out_of_grid = flag;
          end
          OP_QUERY: begin
            if (qx < nx && qy < ny && qz < NMAX) begin
              col = (qx + qz * nx) % (NMAX * NMAX);
              r.is_floor = (floor_tbl[col] == {1'b0, qy});
            end
          end
          OP_NORM: begin
            if (high_seen > low_seen && v > low_seen) begin
              num = (longint'(v - low_seen) << 16) / longint'(high_seen - low_seen);
              r.normalized_intensity = (num > 65535) ? 16'hffff : num[15:0];
            end
          end
          default: ;
        endcase
        r.min_seen_intensity = low_seen;
        r.max_seen_intensity = high_seen;
        expected_results.push_back(r);
      end
      if (m_tvalid && m_tready) begin
        got.cell_x = m_tdata[5:0];
        got.cell_y = m_tdata[11:6];
        got.cell_z = m_tdata[17:12];
        got.flat_index = m_tdata[35:18];
        got.offset_x = m_tdata[69:36];
        got.offset_y = m_tdata[103:70];
        got.offset_z = m_tdata[137:104];
        got.out_of_grid = m_tdata[138];
        got.is_floor = m_tdata[139];
        got.normalized_intensity = m_tdata[155:140];
        got.min_seen_intensity = m_tdata[171:156];
        got.max_seen_intensity = m_tdata[187:172];
        if (expected_results.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          r = expected_results.pop_front();
          checked++;
          if (got.cell_x != r.cell_x) report("cell_x", got.cell_x, r.cell_x);
          if (got.cell_y != r.cell_y) report("cell_y", got.cell_y, r.cell_y);
          if (got.cell_z != r.cell_z) report("cell_z", got.cell_z, r.cell_z);
          if (got.flat_index != r.flat_index)
            report("flat_index", got.flat_index, r.flat_index);
          if (got.offset_x != r.offset_x)
            report("offset_x", $signed(got.offset_x), $signed(r.offset_x));
          if (got.offset_y != r.offset_y)
            report("offset_y", $signed(got.offset_y), $signed(r.offset_y));
          if (got.offset_z != r.offset_z)
            report("offset_z", $signed(got.offset_z), $signed(r.offset_z));
          if (got.out_of_grid != r.out_of_grid)
            report("out_of_grid", got.out_of_grid, r.out_of_grid);
          if (got.is_floor != r.is_floor) report("is_floor", got.is_floor, r.is_floor);
          if (got.normalized_intensity != r.normalized_intensity)
            report("normalized_intensity", got.normalized_intensity,
                   r.normalized_intensity);
          if (got.min_seen_intensity != r.min_seen_intensity)
            report("min_seen_intensity", got.min_seen_intensity, r.min_seen_intensity);
          if (got.max_seen_intensity != r.max_seen_intensity)
            report("max_seen_intensity", got.max_seen_intensity, r.max_seen_intensity);
          if (m_tdata[191:188] != 4'h0) report("tdata pad", m_tdata[191:188], 0);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the point voxel binner: clock, reset, register writes,
// directed and random stimulus, output backpressure and the final verdict.
// Depends on pvb_pkg, point_voxel_binner and pvb_checker.
`timescale 1ns / 1ps
module tb_top;
  import pvb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = OP_BIN;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ORIGIN_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending, checked;
  int cycles = 0;
  int sent = 0;
  int settings_run = 1;
  bit rx_burst = 0;
  bit tx_burst = 0;

  cfg_t cur;

  point_voxel_binner uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  pvb_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .checked
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, burst stretches, and one long hold-off
  initial begin : receiver
    int n;
    int done;
    bit held;
    done = 0;
    held = 0;
    @(negedge clk);
    while (1) begin
      if (!held && done == 150) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        if (done % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        n = rx_burst ? 0 : $urandom_range(0, 18);
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        m_tready <= 1'b1;
      end
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      done++;
      @(negedge clk);
    end
  end

  task automatic send(input logic [1:0] op, input logic [31:0] px, input logic [31:0] py,
                      input logic [31:0] pz, input logic [15:0] inten,
                      input logic [5:0] qx, input logic [5:0] qy, input logic [5:0] qz);
    int n;
    if (sent % 30 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    n = tx_burst ? 0 : $urandom_range(0, 18);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tuser <= op;
    s_tdata <= {6'h0, qz, qy, qx, inten, pz, py, px};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic set_cfg(input cfg_t c);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X; cfg_data <= c.origin_x;    @(negedge clk);
    cfg_index <= REG_ORIGIN_Y; cfg_data <= c.origin_y;    @(negedge clk);
    cfg_index <= REG_ORIGIN_Z; cfg_data <= c.origin_z;    @(negedge clk);
    cfg_index <= REG_SIZE_X;   cfg_data <= c.cell_size_x; @(negedge clk);
    cfg_index <= REG_SIZE_Y;   cfg_data <= c.cell_size_y; @(negedge clk);
    cfg_index <= REG_SIZE_Z;   cfg_data <= c.cell_size_z; @(negedge clk);
    cfg_index <= REG_CELLS_X;  cfg_data <= c.cells_x;     @(negedge clk);
    cfg_index <= REG_CELLS_Y;  cfg_data <= c.cells_y;     @(negedge clk);
    cfg_we <= 1'b0;
    cur = c;
    settings_run++;
  endtask

  function automatic logic [31:0] pick_coord(input logic [31:0] org, input logic [23:0] sz,
                                             input int cells);
    longint span;
    int k;
    k = $urandom_range(0, 19);
    span = longint'(sz == 0 ? 1 : sz) * (cells + 1);
    if (k == 0) return $urandom;
    if (k == 1) return org - $urandom_range(1, 1000);
    return 32'(longint'($signed(org)) + (longint'($urandom) % span));
  endfunction

  task automatic random_items(input int count);
    int nx, ny, k;
    logic [15:0] v;
    nx = (cur.cells_x == 0) ? 1 : (cur.cells_x > 64 ? 64 : cur.cells_x);
    ny = (cur.cells_y == 0) ? 1 : (cur.cells_y > 64 ? 64 : cur.cells_y);
    repeat (count) begin
      k = $urandom_range(0, 9);
      v = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0)
                                      : 16'($urandom);
      if (k < 5)
        send(OP_BIN, pick_coord(cur.origin_x, cur.cell_size_x, nx),
             pick_coord(cur.origin_y, cur.cell_size_y, ny),
             pick_coord(cur.origin_z, cur.cell_size_z, 4), v, 6'($urandom), 6'($urandom),
             6'($urandom));
      else if (k < 8)
        send(OP_QUERY, $urandom, $urandom, $urandom, v,
             ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, nx - 1)),
             ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3)),
             ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4)));
      else
        send(OP_NORM, $urandom, $urandom, $urandom, v, 6'($urandom), 6'($urandom),
             6'($urandom));
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    cur = '{origin_x: 0, origin_y: 0, origin_z: 0, cell_size_x: 256, cell_size_y: 256,
            cell_size_z: 256, cells_x: 10, cells_y: 10};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings: empty range, column never hit, grid edges
    send(OP_NORM,  0, 0, 0, 16'h1234, 0, 0, 0);
    send(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
    send(OP_BIN,   0, 0, 0, 16'h8000, 0, 0, 0);
    send(OP_NORM,  0, 0, 0, 16'h8000, 0, 0, 0);
    send(OP_BIN,   32'd300, 32'd700, 32'd1000, 16'h0000, 0, 0, 0);
    send(OP_BIN,   32'd300, 32'd200, 32'd1000, 16'hffff, 0, 0, 0);
    send(OP_QUERY, 0, 0, 0, 0, 6'd1, 6'd0, 6'd3);
    send(OP_QUERY, 0, 0, 0, 0, 6'd1, 6'd2, 6'd3);
    send(OP_QUERY, 0, 0, 0, 0, 6'd0, 6'd0, 6'd0);
    send(OP_QUERY, 0, 0, 0, 0, 6'd63, 6'd0, 6'd0);
    send(OP_QUERY, 0, 0, 0, 0, 6'd0, 6'd63, 6'd0);
    send(OP_QUERY, 0, 0, 0, 0, 6'd0, 6'd0, 6'd63);
    send(OP_BIN,   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h4000, 0, 0, 0);
    send(OP_BIN,   32'h80000000, 32'h80000000, 32'h80000000, 16'h0001, 0, 0, 0);
    send(OP_BIN,   -32'sd1, 32'd2559, 32'd16383, 16'hfffe, 0, 0, 0);
    send(OP_BIN,   32'd2560, 32'd2560, 32'd16384, 16'h00ff, 0, 0, 0);
    send(OP_NORM,  0, 0, 0, 16'h0000, 0, 0, 0);
    send(OP_NORM,  0, 0, 0, 16'hffff, 0, 0, 0);
    send(OP_NORM,  0, 0, 0, 16'h7fff, 0, 0, 0);
    random_items(60);

    // smallest cells, largest counts
    c = '{0, 0, 0, 1, 1, 1, 64, 64};
    set_cfg(c);
    send(OP_BIN, 32'd63, 32'd63, 32'd63, 16'h1111, 0, 0, 0);
    send(OP_QUERY, 0, 0, 0, 0, 6'd63, 6'd63, 6'd63);
    random_items(80);

    // extreme origins, largest cells, one cell in x and y: offsets saturate
    c = '{32'h80000000, 32'h7fffffff, 0, 24'hffffff, 24'hffffff, 24'hffffff, 1, 1};
    set_cfg(c);
    send(OP_BIN, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h2222, 0, 0, 0);
    send(OP_BIN, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'h3333, 0, 0, 0);
    random_items(80);

    // zero cell size and out-of-range counts; table kept from earlier counts
    c = '{32'd100, -32'sd100, 32'd0, 0, 0, 0, 0, 7'd127};
    set_cfg(c);
    random_items(80);

    repeat (3) begin
      c.origin_x = $urandom;
      c.origin_y = $urandom;
      c.origin_z = $urandom;
      c.cell_size_x = $urandom_range(1, 2000);
      c.cell_size_y = $urandom_range(1, 2000);
      c.cell_size_z = 24'($urandom);
      c.cells_x = $urandom_range(1, 64);
      c.cells_y = $urandom_range(1, 8);
      set_cfg(c);
      random_items(85);
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             sent, settings_run, checked);
    $display("bin, floor query and normalize operations with random stalls on both sides");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pvb_pkg.sv
rtl/pvb_ram.sv
rtl/pvb_div.sv
rtl/pvb_front.sv
rtl/pvb_queue.sv
rtl/pvb_back.sv
rtl/point_voxel_binner.sv
verif/pvb_checker.sv
verif/tb_top.sv
